// ===== rtl/two_level_sequential_stream_detector_defines.svh =====
// assertion macros for the stream detector checker
`ifndef TWO_LEVEL_SEQUENTIAL_STREAM_DETECTOR_DEFINES_SVH
`define TWO_LEVEL_SEQUENTIAL_STREAM_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define TLSSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define TLSSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlssd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlssd_pkg
// shared types, sizes and codes of the two-level stream detector
// ----------------------------------------------------------------------------
`default_nettype none

package tlssd_pkg;

    localparam int Q_N   = 16;
    localparam int C_N   = 64;
    localparam int Q_IW  = (Q_N > 1) ? $clog2(Q_N) : 1;
    localparam int C_IW  = (C_N > 1) ? $clog2(C_N) : 1;
    localparam int SEL_W = (Q_IW > C_IW) ? Q_IW : C_IW;
    localparam int N_MAX = (Q_N > C_N) ? Q_N : C_N;
    localparam int CNT_W = $clog2(N_MAX + 2);

    localparam logic [1:0] OUT_IGNORED    = 2'd0;
    localparam logic [1:0] OUT_CORE_HIT   = 2'd1;
    localparam logic [1:0] OUT_QUEUE_HIT  = 2'd2;
    localparam logic [1:0] OUT_NEW_STREAM = 2'd3;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_REQ_COUNT = 2'd1;
    localparam logic [1:0] CFG_BYTE_THR  = 2'd2;

    typedef struct packed {
        logic        dir;
        logic [63:0] end_addr;
        logic [63:0] bytes;
        logic [31:0] reqs;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CSCAN,
        ST_CCALC,
        ST_CWR,
        ST_QSCAN,
        ST_QCALC,
        ST_QWR,
        ST_PROMO,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_clr;
        logic scan_core;
        logic scan_q;
        logic calc_core;
        logic core_wr;
        logic calc_q;
        logic q_wr;
        logic promo;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic en;
        logic scan_done;
        logic core_hit;
        logic promote;
        logic out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

// ===== rtl/tlssd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlssd_ctrl
// sequencer: core scan, queue scan, table updates, promotion, result
// ----------------------------------------------------------------------------
`default_nettype none

module tlssd_ctrl
    import tlssd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd,
    output logic          o_req_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = i_sts.en ? ST_CSCAN : ST_DONE;
                end
            end
            ST_CSCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.core_hit ? ST_CCALC : ST_QSCAN;
                end
            end
            ST_CCALC: n_state = ST_CWR;
            ST_CWR:   n_state = ST_DONE;
            ST_QSCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_QCALC;
                end
            end
            ST_QCALC: n_state = ST_QWR;
            ST_QWR:   n_state = i_sts.promote ? ST_PROMO : ST_DONE;
            ST_PROMO: n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_req_stall    = 1'b0;
                o_cmd.scan_clr = 1'b1;
                o_cmd.accept   = i_req_valid;
            end
            ST_CSCAN: begin
                o_cmd.scan_core = 1'b1;
                o_cmd.scan_clr  = i_sts.scan_done && !i_sts.core_hit;
            end
            ST_CCALC: o_cmd.calc_core = 1'b1;
            ST_CWR:   o_cmd.core_wr   = 1'b1;
            ST_QSCAN: o_cmd.scan_q    = 1'b1;
            ST_QCALC: o_cmd.calc_q    = 1'b1;
            ST_QWR:   o_cmd.q_wr      = 1'b1;
            ST_PROMO: o_cmd.promo     = 1'b1;
            ST_DONE:  o_cmd.out_load  = i_sts.out_free;
            default:  o_cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tlssd_dp.sv =====
// ----------------------------------------------------------------------------
// tlssd_dp
// stream tables, lru ranks, scan compare, entry update and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tlssd_dp
    import tlssd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic [63:0] i_req_address,
    input  wire logic [31:0] i_req_length,
    input  wire logic        i_req_direction,
    input  wire logic        i_check_core_table,
    input  wire logic        i_res_stall,
    input  wire t_ctl_cmd    i_cmd,
    output t_ctl_sts         o_sts,
    output logic             o_res_valid,
    output logic [1:0]       o_outcome,
    output logic             o_promoted,
    output logic [63:0]      o_stream_end,
    output logic [63:0]      o_stream_bytes,
    output logic [31:0]      o_stream_requests
);

    logic        r_cfg_en;
    logic [31:0] r_cfg_cnt;
    logic [31:0] r_cfg_thr;

    logic [63:0] r_addr;
    logic [31:0] r_len;
    logic        r_rw;
    logic        r_chk;
    logic        r_ignore;

    logic            r_qvalid [Q_N];
    logic            r_cvalid [C_N];
    logic [Q_IW-1:0] r_qrank  [Q_N];
    logic [C_IW-1:0] r_crank  [C_N];

    t_entry mem_q [Q_N];
    t_entry mem_c [C_N];
    t_entry r_qrd;
    t_entry r_crd;

    logic [CNT_W-1:0] r_cnt;
    logic             r_best_found;
    logic [SEL_W-1:0] r_best_idx;
    logic [SEL_W-1:0] r_best_rank;
    t_entry           r_best;
    logic [C_IW-1:0]  r_c_old;
    logic [Q_IW-1:0]  r_q_old;

    logic [SEL_W-1:0] r_sel_idx;
    logic [SEL_W-1:0] r_sel_rank;
    t_entry           r_new;
    logic [1:0]       r_outcome;
    logic             r_promote;

    logic        r_ovalid;
    logic [1:0]  r_o_outcome;
    logic        r_o_promoted;
    logic [63:0] r_o_end;
    logic [63:0] r_o_bytes;
    logic [31:0] r_o_reqs;

    // scan evaluation: entry r_cnt-1, its table data arrived this cycle
    logic [CNT_W-1:0] s_e;
    logic             s_ev;
    logic             s_valid;
    logic [SEL_W-1:0] s_rank;
    t_entry           s_data;
    logic             s_hit;
    logic             s_better;
    logic [63:0]      s_sum_end;
    logic             s_promote;

    assign s_e    = r_cnt - CNT_W'(1);
    assign s_ev   = (r_cnt != '0) &&
                    ((i_cmd.scan_core && (r_cnt <= CNT_W'(C_N))) ||
                     (i_cmd.scan_q && (r_cnt <= CNT_W'(Q_N))));
    assign s_valid = i_cmd.scan_core ? r_cvalid[s_e[C_IW-1:0]] : r_qvalid[s_e[Q_IW-1:0]];
    assign s_rank  = i_cmd.scan_core ? SEL_W'(r_crank[s_e[C_IW-1:0]])
                                     : SEL_W'(r_qrank[s_e[Q_IW-1:0]]);
    assign s_data  = i_cmd.scan_core ? r_crd : r_qrd;
    assign s_hit   = s_ev && s_valid && (s_data.dir == r_rw) && (s_data.end_addr == r_addr);
    assign s_better = s_hit && (!r_best_found || (s_data.bytes > r_best.bytes));
    assign s_sum_end = r_addr + {32'd0, r_len};
    assign s_promote = ((r_cfg_thr != 32'd0) && (r_new.bytes >= {32'd0, r_cfg_thr})) ||
                       (r_new.reqs >= r_cfg_cnt);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_en  <= 1'b0;
            r_cfg_cnt <= 32'd8;
            r_cfg_thr <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:    r_cfg_en  <= i_cfg_data[0];
                CFG_REQ_COUNT: r_cfg_cnt <= i_cfg_data;
                CFG_BYTE_THR:  r_cfg_thr <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr   <= i_req_address;
            r_len    <= i_req_length;
            r_rw     <= i_req_direction;
            r_chk    <= i_check_core_table;
            r_ignore <= !r_cfg_en;
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_wr) begin
            mem_q[r_sel_idx[Q_IW-1:0]] <= r_new;
        end
        if (i_cmd.scan_q && (r_cnt < CNT_W'(Q_N))) begin
            r_qrd <= mem_q[r_cnt[Q_IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.core_wr) begin
            mem_c[r_sel_idx[C_IW-1:0]] <= r_new;
        end else if (i_cmd.promo) begin
            mem_c[r_c_old] <= r_new;
        end
        if (i_cmd.scan_core && (r_cnt < CNT_W'(C_N))) begin
            r_crd <= mem_c[r_cnt[C_IW-1:0]];
        end
    end

    // scan counter, best hit and oldest entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_best_found <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_cnt        <= '0;
            r_best_found <= 1'b0;
        end else if (i_cmd.scan_core || i_cmd.scan_q) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (s_better) begin
                r_best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_better) begin
            r_best_idx  <= SEL_W'(s_e);
            r_best_rank <= s_rank;
            r_best      <= s_data;
        end
        if (s_ev && (s_rank == '0)) begin
            if (i_cmd.scan_core) begin
                r_c_old <= s_e[C_IW-1:0];
            end else begin
                r_q_old <= s_e[Q_IW-1:0];
            end
        end
    end

    // updated entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_core || (i_cmd.calc_q && r_best_found)) begin
            r_new.dir      <= r_rw;
            r_new.end_addr <= s_sum_end;
            r_new.bytes    <= r_best.bytes + {32'd0, r_len};
            r_new.reqs     <= r_best.reqs + 32'd1;
            r_sel_idx      <= r_best_idx;
            r_sel_rank     <= r_best_rank;
            r_outcome      <= i_cmd.calc_core ? OUT_CORE_HIT : OUT_QUEUE_HIT;
        end else if (i_cmd.calc_q) begin
            r_new.dir      <= r_rw;
            r_new.end_addr <= s_sum_end;
            r_new.bytes    <= {32'd0, r_len};
            r_new.reqs     <= 32'd1;
            r_sel_idx      <= SEL_W'(r_q_old);
            r_sel_rank     <= '0;
            r_outcome      <= OUT_NEW_STREAM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_promote <= 1'b0;
        end else if (i_cmd.accept) begin
            r_promote <= 1'b0;
        end else if (i_cmd.q_wr) begin
            r_promote <= s_promote;
        end
    end

    // queue valid bits and lru ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Q_N; i++) begin
                r_qvalid[i] <= 1'b0;
                r_qrank[i]  <= Q_IW'(i);
            end
        end else if (i_cmd.q_wr) begin
            for (int i = 0; i < Q_N; i++) begin
                if (Q_IW'(i) == r_sel_idx[Q_IW-1:0]) begin
                    r_qvalid[i] <= 1'b1;
                    r_qrank[i]  <= Q_IW'(Q_N - 1);
                end else if (r_qrank[i] > r_sel_rank[Q_IW-1:0]) begin
                    r_qrank[i] <= r_qrank[i] - Q_IW'(1);
                end
            end
        end else if (i_cmd.promo) begin
            // promoted entry drops from newest to oldest
            for (int i = 0; i < Q_N; i++) begin
                if (Q_IW'(i) == r_sel_idx[Q_IW-1:0]) begin
                    r_qvalid[i] <= 1'b0;
                    r_qrank[i]  <= '0;
                end else if (r_qrank[i] < Q_IW'(Q_N - 1)) begin
                    r_qrank[i] <= r_qrank[i] + Q_IW'(1);
                end
            end
        end
    end

    // core valid bits and lru ranks
    logic [C_IW-1:0] c_sel;
    logic [C_IW-1:0] c_sel_rank;

    assign c_sel      = i_cmd.core_wr ? r_sel_idx[C_IW-1:0] : r_c_old;
    assign c_sel_rank = i_cmd.core_wr ? r_sel_rank[C_IW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < C_N; i++) begin
                r_cvalid[i] <= 1'b0;
                r_crank[i]  <= C_IW'(i);
            end
        end else if (i_cmd.core_wr || i_cmd.promo) begin
            for (int i = 0; i < C_N; i++) begin
                if (C_IW'(i) == c_sel) begin
                    r_cvalid[i] <= 1'b1;
                    r_crank[i]  <= C_IW'(C_N - 1);
                end else if (r_crank[i] > c_sel_rank) begin
                    r_crank[i] <= r_crank[i] - C_IW'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_res_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_ignore) begin
                r_o_outcome  <= OUT_IGNORED;
                r_o_promoted <= 1'b0;
                r_o_end      <= '0;
                r_o_bytes    <= '0;
                r_o_reqs     <= '0;
            end else begin
                r_o_outcome  <= r_outcome;
                r_o_promoted <= r_promote;
                r_o_end      <= r_new.end_addr;
                r_o_bytes    <= r_new.bytes;
                r_o_reqs     <= r_new.reqs;
            end
        end
    end

    always_comb begin
        o_sts.en        = r_cfg_en;
        o_sts.scan_done = i_cmd.scan_core ? (r_cnt == CNT_W'(C_N + 1))
                                          : (r_cnt == CNT_W'(Q_N + 1));
        o_sts.core_hit  = r_chk && r_best_found;
        // decided from the entry being written, while in the queue write state
        o_sts.promote   = s_promote;
        o_sts.out_free  = !r_ovalid || !i_res_stall;
    end

    assign o_res_valid       = r_ovalid;
    assign o_outcome         = r_o_outcome;
    assign o_promoted        = r_o_promoted;
    assign o_stream_end      = r_o_end;
    assign o_stream_bytes    = r_o_bytes;
    assign o_stream_requests = r_o_reqs;

endmodule

`default_nettype wire

// ===== rtl/two_level_sequential_stream_detector.sv =====
// ----------------------------------------------------------------------------
// two_level_sequential_stream_detector
// sequential stream detector with a queue table and a core lru table
// ----------------------------------------------------------------------------
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+------------------------------------
//  request   | i_req_valid  | o_req_stall  | address, length, direction, core flag
//  result    | o_res_valid  | i_res_stall  | outcome, promoted, end, bytes, requests
//  config    | i_cfg_we     | none         | i_cfg_index, i_cfg_data
//
//  one word at a time: the core table memory and, on a core miss, the queue
//  table memory are scanned one entry per cycle.
//  a disabled detector skips both scans and answers with an ignored result.
//  synchronous reset, no clearing pass: valid bits and ranks reset at once.
//  the next request is taken while the previous result waits on i_res_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_sequential_stream_detector
    import tlssd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_req_valid,
    output logic             o_req_stall,
    input  wire logic [63:0] i_req_address,
    input  wire logic [31:0] i_req_length,
    input  wire logic        i_req_direction,
    input  wire logic        i_check_core_table,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic [1:0]       o_outcome,
    output logic             o_promoted,
    output logic [63:0]      o_stream_end,
    output logic [63:0]      o_stream_bytes,
    output logic [31:0]      o_stream_requests
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    tlssd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_req_stall (o_req_stall)
    );

    tlssd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_req_address      (i_req_address),
        .i_req_length       (i_req_length),
        .i_req_direction    (i_req_direction),
        .i_check_core_table (i_check_core_table),
        .i_res_stall        (i_res_stall),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_res_valid        (o_res_valid),
        .o_outcome          (o_outcome),
        .o_promoted         (o_promoted),
        .o_stream_end       (o_stream_end),
        .o_stream_bytes     (o_stream_bytes),
        .o_stream_requests  (o_stream_requests)
    );

endmodule

`default_nettype wire

// ===== rtl/tlssd_chk.sv =====
// ----------------------------------------------------------------------------
// tlssd_chk
// port-level checks of the stream detector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_level_sequential_stream_detector_defines.svh"

module tlssd_chk
    import tlssd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [1:0]  i_cfg_index,
    input wire logic [31:0] i_cfg_data,
    input wire logic        i_req_valid,
    input wire logic        o_req_stall,
    input wire logic [63:0] i_req_address,
    input wire logic [31:0] i_req_length,
    input wire logic        i_req_direction,
    input wire logic        i_check_core_table,
    input wire logic        o_res_valid,
    input wire logic        i_res_stall,
    input wire logic [1:0]  o_outcome,
    input wire logic        o_promoted,
    input wire logic [63:0] o_stream_end,
    input wire logic [63:0] o_stream_bytes,
    input wire logic [31:0] o_stream_requests
);

    // an accepted word leaves the request side busy, stalling further requests
    `TLSSD_ASSERT_NXT(a_busy_after_accept, i_req_valid && !o_req_stall, o_req_stall, "request taken while busy")

    // ignored request carries an all-zero result
    `TLSSD_ASSERT_IMP(a_ignored_zero, o_res_valid && (o_outcome == OUT_IGNORED), !o_promoted && (o_stream_end == 64'd0) && (o_stream_bytes == 64'd0) && (o_stream_requests == 32'd0), "ignored result not zero")

    // only queue outcomes promote
    `TLSSD_ASSERT_IMP(a_promote_queue, o_res_valid && o_promoted, (o_outcome == OUT_QUEUE_HIT) || (o_outcome == OUT_NEW_STREAM), "promotion on non-queue outcome")

    // a new stream result carries exactly one request
    `TLSSD_ASSERT_IMP(a_reqs_nonzero, o_res_valid && (o_outcome == OUT_NEW_STREAM), o_stream_requests == 32'd1, "new stream request total not one")

    // stalled result stays offered
    `TLSSD_ASSERT_NXT(a_res_hold, o_res_valid && i_res_stall, o_res_valid, "result dropped under stall")

endmodule

bind two_level_sequential_stream_detector tlssd_chk u_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level sequential stream detector. A local
// model of the queue and core tables predicts every result word. Directed
// tests cover the disabled detector, hits, ties, promotion rules and
// wrap-around. Random streams then run under three idle patterns and several
// promotion settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import tlssd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         N_CURSORS  = 24;

    typedef struct {
        logic [1:0]  outcome;
        logic        promoted;
        logic [63:0] end_addr;
        logic [63:0] bytes;
        logic [31:0] reqs;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_req_valid = 1'b0;
    logic        o_req_stall;
    logic [63:0] i_req_address = '0;
    logic [31:0] i_req_length = '0;
    logic        i_req_direction = 1'b0;
    logic        i_check_core_table = 1'b0;
    logic        o_res_valid;
    logic        i_res_stall = 1'b0;
    logic [1:0]  o_outcome;
    logic        o_promoted;
    logic [63:0] o_stream_end;
    logic [63:0] o_stream_bytes;
    logic [31:0] o_stream_requests;

    two_level_sequential_stream_detector dut (.*);

    // model state
    logic        mdl_enable;
    logic [31:0] mdl_req_count;
    logic [31:0] mdl_byte_thr;
    logic        q_valid [Q_N];
    logic        q_dir   [Q_N];
    logic [63:0] q_end   [Q_N];
    logic [63:0] q_bytes [Q_N];
    logic [31:0] q_reqs  [Q_N];
    logic [3:0]  q_rank  [Q_N];
    logic        c_valid [C_N];
    logic        c_dir   [C_N];
    logic [63:0] c_end   [C_N];
    logic [63:0] c_bytes [C_N];
    logic [31:0] c_reqs  [C_N];
    logic [5:0]  c_rank  [C_N];

    t_result     expected_results[$];
    int          n_errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    logic [63:0] cur_addr [N_CURSORS];
    logic        cur_dir  [N_CURSORS];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    task automatic model_reset();
        mdl_enable    = 1'b0;
        mdl_req_count = 32'd8;
        mdl_byte_thr  = 32'd0;
        for (int i = 0; i < Q_N; i++) begin
            q_valid[i] = 1'b0; q_dir[i] = 1'b0; q_end[i] = 64'(i) * 64'd4096;
            q_bytes[i] = 64'd0; q_reqs[i] = 32'd0; q_rank[i] = 4'(i);
        end
        for (int i = 0; i < C_N; i++) begin
            c_valid[i] = 1'b0; c_dir[i] = 1'b0; c_end[i] = 64'(i) * 64'd4096;
            c_bytes[i] = 64'd0; c_reqs[i] = 32'd0; c_rank[i] = 6'(i);
        end
    endtask

    task automatic predict_stream(input logic [63:0] addr, input logic [31:0] len,
                                  input logic dir, input logic chk, output t_result r);
        int          e;
        int          d;
        logic [5:0]  cr;
        logic [3:0]  qr;
        r = '{OUT_IGNORED, 1'b0, 64'd0, 64'd0, 32'd0};
        if (!mdl_enable) return;
        if (chk) begin
            e = -1;
            for (int i = 0; i < C_N; i++)
                if (c_valid[i] && c_dir[i] == dir && c_end[i] == addr &&
                    (e < 0 || c_bytes[i] > c_bytes[e])) e = i;
            if (e >= 0) begin
                c_end[e]   = addr + 64'(len);
                c_bytes[e] = c_bytes[e] + 64'(len);
                c_reqs[e]  = c_reqs[e] + 32'd1;
                cr = c_rank[e];
                for (int i = 0; i < C_N; i++) if (c_rank[i] > cr) c_rank[i]--;
                c_rank[e] = 6'(C_N - 1);
                r = '{OUT_CORE_HIT, 1'b0, c_end[e], c_bytes[e], c_reqs[e]};
                return;
            end
        end
        e = -1;
        for (int i = 0; i < Q_N; i++)
            if (q_valid[i] && q_dir[i] == dir && q_end[i] == addr &&
                (e < 0 || q_bytes[i] > q_bytes[e])) e = i;
        if (e >= 0) begin
            q_end[e]   = addr + 64'(len);
            q_bytes[e] = q_bytes[e] + 64'(len);
            q_reqs[e]  = q_reqs[e] + 32'd1;
            r.outcome  = OUT_QUEUE_HIT;
        end else begin
            e = 0;
            for (int i = 1; i < Q_N; i++) if (q_rank[i] < q_rank[e]) e = i;
            q_dir[e] = dir; q_end[e] = addr + 64'(len);
            q_bytes[e] = 64'(len); q_reqs[e] = 32'd1; q_valid[e] = 1'b1;
            r.outcome = OUT_NEW_STREAM;
        end
        qr = q_rank[e];
        for (int i = 0; i < Q_N; i++) if (q_rank[i] > qr) q_rank[i]--;
        q_rank[e] = 4'(Q_N - 1);
        r.promoted = (mdl_byte_thr != 0 && q_bytes[e] >= 64'(mdl_byte_thr)) ||
                     q_reqs[e] >= mdl_req_count;
        r.end_addr = q_end[e]; r.bytes = q_bytes[e]; r.reqs = q_reqs[e];
        if (r.promoted) begin
            d = 0;
            for (int i = 1; i < C_N; i++) if (c_rank[i] < c_rank[d]) d = i;
            c_dir[d] = q_dir[e]; c_end[d] = q_end[e]; c_bytes[d] = q_bytes[e];
            c_reqs[d] = q_reqs[e]; c_valid[d] = 1'b1;
            cr = c_rank[d];
            for (int i = 0; i < C_N; i++) if (c_rank[i] > cr) c_rank[i]--;
            c_rank[d] = 6'(C_N - 1);
            q_valid[e] = 1'b0;
            qr = q_rank[e];
            for (int i = 0; i < Q_N; i++) if (q_rank[i] < qr) q_rank[i]++;
            q_rank[e] = 4'd0;
        end
    endtask

    task automatic send_req(input logic [63:0] addr, input logic [31:0] len,
                            input logic dir, input logic chk);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid        <= 1'b1;
        i_req_address      <= addr;
        i_req_length       <= len;
        i_req_direction    <= dir;
        i_check_core_table <= chk;
        do @(posedge i_clk); while (o_req_stall);
        predict_stream(addr, len, dir, chk, r);
        expected_results.push_back(r);
    endtask

    // hold off until every word has come back
    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_ENABLE:    mdl_enable    = val[0];
            CFG_REQ_COUNT: mdl_req_count = val;
            CFG_BYTE_THR:  mdl_byte_thr  = val;
            default: ;
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result x;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word outcome=%0d", $realtime, o_outcome);
                n_errors++;
            end else begin
                x = expected_results.pop_front();
                if (x.outcome !== o_outcome || x.promoted !== o_promoted ||
                    x.end_addr !== o_stream_end || x.bytes !== o_stream_bytes ||
                    x.reqs !== o_stream_requests) begin
                    $display("%0t: mismatch expected %0d/%0d/%h/%h/%h actual %0d/%0d/%h/%h/%h",
                             $realtime, x.outcome, x.promoted, x.end_addr, x.bytes,
                             x.reqs, o_outcome, o_promoted, o_stream_end,
                             o_stream_bytes, o_stream_requests);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk)
        i_res_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic test_disabled();
        write_cfg(CFG_ENABLE, 32'd0);
        send_req(64'h0, 32'd16, 1'b0, 1'b1);
        send_req('1, '1, 1'b1, 1'b0);
        write_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_cfg(CFG_ENABLE, 32'hFFFF_FFFF);
    endtask

    task automatic test_streams_and_promotion();
        // default count of eight promotes on the eighth word
        for (int i = 0; i < 8; i++) send_req(64'h1000 + 64'(i) * 64'h200, 32'h200, 1'b0, 1'b0);
        send_req(64'h2000, 32'h100, 1'b0, 1'b1);  // core hit
        send_req(64'h2100, 32'h100, 1'b1, 1'b1);  // wrong direction, core miss
        send_req(64'h2100, 32'h100, 1'b0, 1'b0);  // core skipped
        // two streams ending together, bigger one wins
        send_req(64'h10000, 32'h100, 1'b1, 1'b0);
        send_req(64'h100F0, 32'h10, 1'b1, 1'b0);
        send_req(64'h10100, 32'h8, 1'b1, 1'b0);
        // equal totals tie, lowest index wins
        send_req(64'h30000, 32'h40, 1'b0, 1'b0);
        send_req(64'h30000, 32'h40, 1'b0, 1'b0);
        send_req(64'h30040, 32'h40, 1'b0, 1'b1);
    endtask

    task automatic test_promotion_rules();
        write_cfg(CFG_REQ_COUNT, 32'd0);
        send_req(64'h5_0000, 32'h0, 1'b1, 1'b0);
        send_req(64'h5_0000, 32'h20, 1'b1, 1'b1);
        write_cfg(CFG_REQ_COUNT, 32'hFFFF_FFFF);
        write_cfg(CFG_BYTE_THR, 32'h1000);
        send_req(64'h6_0000, 32'h800, 1'b0, 1'b0);
        send_req(64'h6_0800, 32'h800, 1'b0, 1'b0);
        write_cfg(CFG_BYTE_THR, 32'hFFFF_FFFF);
        send_req(64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_req(64'h0000_0000_FFFF_FEFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_req('1, 32'h1, 1'b0, 1'b0);
        send_req(64'h0, 32'h1, 1'b0, 1'b1);
    endtask

    task automatic run_random(input int n_items);
        int          k;
        int          r;
        logic [31:0] len;
        for (int i = 0; i < N_CURSORS; i++) begin
            cur_addr[i] = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(1 << 20));
            cur_dir[i]  = 1'($urandom_range(1));
        end
        for (int n = 0; n < n_items; n++) begin
            if (n == n_items / 2) drain();
            k = $urandom_range(N_CURSORS - 1);
            r = $urandom_range(99);
            if (r < 85) begin
                case ($urandom_range(19))
                    0:       len = $urandom;
                    1:       len = 32'd0;
                    default: len = 32'($urandom_range(1, 4096));
                endcase
                send_req(cur_addr[k], len, cur_dir[k], $urandom_range(3) != 0);
                cur_addr[k] = cur_addr[k] + 64'(len);
            end else if (r < 92) begin
                cur_addr[k] = {$urandom, $urandom};
                cur_dir[k]  = 1'($urandom_range(1));
            end else begin
                send_req({$urandom, $urandom}, $urandom, 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_random_phases();
        write_cfg(CFG_REQ_COUNT, 32'd8);
        write_cfg(CFG_BYTE_THR, 32'd0);
        send_idle_pct = 28; recv_idle_pct = 86;
        run_random(650);
        write_cfg(CFG_REQ_COUNT, 32'd3);
        write_cfg(CFG_BYTE_THR, 32'd6000);
        send_idle_pct = 86; recv_idle_pct = 28;
        run_random(650);
        write_cfg(CFG_REQ_COUNT, 32'd1);
        write_cfg(CFG_BYTE_THR, 32'hFFFF_FFFF);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(300);
        write_cfg(CFG_REQ_COUNT, 32'd12);
        write_cfg(CFG_BYTE_THR, 32'd1);
        run_random(300);
    endtask

    initial begin
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled();
        test_streams_and_promotion();
        test_promotion_rules();
        test_random_phases();
        drain();
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== two_level_sequential_stream_detector.f =====
+incdir+rtl
rtl/tlssd_pkg.sv
rtl/tlssd_ctrl.sv
rtl/tlssd_dp.sv
rtl/two_level_sequential_stream_detector.sv
rtl/tlssd_chk.sv
tb/tb.sv
